@@ rtl/wss_pkg.sv @@
// ---------------------------------------------------------------------------
// Windowed sample statistics package
// Shared constants, operation codes and the query sequencer state type.
// ---------------------------------------------------------------------------
package wss_pkg;

	localparam int WINDOW_DEPTH_DEF  = 1024;
	localparam int CHANNEL_COUNT_DEF = 11;
	localparam int CAP_RESET         = 1024;

	localparam int VALUE_W  = 32;
	localparam int TIME_W   = 64;
	localparam int SD_W     = 31;
	localparam int COUNT_W  = 11;
	localparam int CHAN_W   = 4;
	localparam int OP_W     = 2;

	localparam int SQRT_STEPS = 32;

	localparam logic [OP_W-1:0] OP_ADD   = 2'd0;
	localparam logic [OP_W-1:0] OP_QUERY = 2'd1;
	localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SUM,
		ST_MEAN_DIV,
		ST_VAR,
		ST_VAR_DIV,
		ST_SQRT,
		ST_MED_SCAN,
		ST_MED_EVAL,
		ST_DONE
	} wss_state_t;

endpackage

@@ rtl/wss_store.sv @@
// ---------------------------------------------------------------------------
// Sample and timestamp ring memory
// One write port; two registered read ports on the samples, one on the times.
// ---------------------------------------------------------------------------
module wss_store #(
	parameter int ENTRIES = 11264,
	parameter int AW      = 14
) (
	input  logic                          clk,
	input  logic                          we,
	input  logic [AW-1:0]                 waddr,
	input  logic [wss_pkg::VALUE_W-1:0]   wsample,
	input  logic [wss_pkg::TIME_W-1:0]    wtime,
	input  logic [AW-1:0]                 ra_addr,
	output logic [wss_pkg::VALUE_W-1:0]   ra_data,
	input  logic [AW-1:0]                 rb_addr,
	output logic [wss_pkg::VALUE_W-1:0]   rb_data,
	input  logic [AW-1:0]                 rt_addr,
	output logic [wss_pkg::TIME_W-1:0]    rt_data
);

	logic [wss_pkg::VALUE_W-1:0] smem [ENTRIES];
	logic [wss_pkg::TIME_W-1:0]  tmem [ENTRIES];

	always_ff @(posedge clk) begin
		if (we) begin
			smem[waddr] <= wsample;
			tmem[waddr] <= wtime;
		end
		ra_data <= smem[ra_addr];
		rb_data <= smem[rb_addr];
		rt_data <= tmem[rt_addr];
	end

endmodule

@@ rtl/wss_div.sv @@
// ---------------------------------------------------------------------------
// Iterative unsigned divider
// Restoring division, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module wss_div #(
	parameter int DW = 75,
	parameter int VW = 11
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] dividend,
	input  logic [VW-1:0] divisor,
	output logic          done,
	output logic [DW-1:0] quotient
);

	localparam int NW = $clog2(DW + 1);

	logic          busy_q;
	logic          done_q;
	logic [NW-1:0] cnt_q;
	logic [VW-1:0] rem_q;
	logic [DW-1:0] quo_q;
	logic [VW:0]   r2;
	logic [VW:0]   r_next;
	logic          ge;

	always_comb begin
		r2     = {rem_q, quo_q[DW-1]};
		ge     = r2 >= {1'b0, divisor};
		r_next = ge ? r2 - {1'b0, divisor} : r2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + NW'(1);
				if (cnt_q == NW'(DW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= r_next[VW-1:0];
			quo_q <= {quo_q[DW-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

@@ rtl/wss_sqrt.sv @@
// ---------------------------------------------------------------------------
// Iterative integer square root
// Floor square root of a 64-bit value, two radicand bits per cycle.
// ---------------------------------------------------------------------------
module wss_sqrt (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] radicand,
	output logic        done,
	output logic [31:0] root
);

	localparam int NW = $clog2(wss_pkg::SQRT_STEPS);

	logic          busy_q;
	logic          done_q;
	logic [NW-1:0] cnt_q;
	logic [63:0]   x_q;
	logic [63:0]   res_q;
	logic [63:0]   bit_q;
	logic [64:0]   trial;
	logic          take;

	always_comb begin
		trial = {1'b0, res_q} + {1'b0, bit_q};
		take  = {1'b0, x_q} >= trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + NW'(1);
				if (cnt_q == NW'(wss_pkg::SQRT_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q   <= radicand;
			res_q <= '0;
			bit_q <= 64'h4000_0000_0000_0000;
		end else if (busy_q) begin
			if (take) begin
				x_q   <= x_q - trial[63:0];
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign done = done_q;
	assign root = res_q[31:0];

endmodule

@@ rtl/windowed_sample_statistics.sv @@
// ---------------------------------------------------------------------------
// Windowed sample statistics
// Per-channel sample rings with min, max, mean, median and deviation queries.
// ---------------------------------------------------------------------------
// An add or clear item leaves busy low, so adds can be issued every cycle
// while no query holds busy high and no capacity write is made. A query
// of a channel that holds samples keeps busy high while it runs, and its
// result appears in the cycle in which busy falls. The median search
// compares every held sample against every held sample, itself included,
// through the two read ports of the sample memory, and that loop dominates.
// A query of an empty channel answers on the next cycle without busy.
// Each result appears for exactly one cycle with result_valid high; the
// receiver has no way to hold it, so it must capture it on that cycle.
// A capacity write that changes the effective capacity empties all channels.
// ---------------------------------------------------------------------------
module windowed_sample_statistics #(
	parameter int WINDOW_DEPTH  = wss_pkg::WINDOW_DEPTH_DEF,
	parameter int CHANNEL_COUNT = wss_pkg::CHANNEL_COUNT_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic [wss_pkg::OP_W-1:0]            operation,
	input  logic [wss_pkg::CHAN_W-1:0]          channel,
	input  logic signed [wss_pkg::VALUE_W-1:0]  sample_value,
	input  logic [wss_pkg::TIME_W-1:0]          sample_time,
	input  logic                                window_capacity_wr,
	input  logic [wss_pkg::COUNT_W-1:0]         window_capacity,
	output logic                                result_valid,
	output logic signed [wss_pkg::VALUE_W-1:0]  lowest_value,
	output logic signed [wss_pkg::VALUE_W-1:0]  highest_value,
	output logic signed [wss_pkg::VALUE_W-1:0]  mean_value,
	output logic signed [wss_pkg::VALUE_W-1:0]  middle_value,
	output logic [wss_pkg::SD_W-1:0]            spread_value,
	output logic [wss_pkg::COUNT_W-1:0]         held_samples,
	output logic [wss_pkg::TIME_W-1:0]          first_time,
	output logic [wss_pkg::TIME_W-1:0]          last_time
);

	localparam int VW       = wss_pkg::VALUE_W;
	localparam int PW       = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
	localparam int CW       = $clog2(WINDOW_DEPTH + 1);
	localparam int ENTRIES  = CHANNEL_COUNT * WINDOW_DEPTH;
	localparam int AW       = $clog2(ENTRIES);
	localparam int CHW      = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
	localparam int SW       = VW + CW;
	localparam int DW       = 2 * VW + CW;
	localparam int CAP_INIT = (wss_pkg::CAP_RESET > WINDOW_DEPTH) ? WINDOW_DEPTH
	                          : wss_pkg::CAP_RESET;

	function automatic logic [PW-1:0] ring_inc(input logic [PW-1:0] p,
	                                           input logic [CW-1:0] cap);
		logic [CW-1:0] nxt;
		nxt = CW'(p) + CW'(1);
		return (nxt == cap) ? '0 : PW'(nxt);
	endfunction

	wss_pkg::wss_state_t state_q, state_d;

	// Per-channel ring pointers
	logic [CW-1:0] cap_q;
	logic [PW-1:0] wp_q   [CHANNEL_COUNT];
	logic [PW-1:0] old_q  [CHANNEL_COUNT];
	logic [CW-1:0] held_q [CHANNEL_COUNT];

	logic [CW-1:0]  cap_new;
	logic           accept;
	logic           ch_ok;
	logic [CHW-1:0] ch_idx;
	logic [AW-1:0]  base_in;
	logic [PW-1:0]  newest_in;

	// Query working registers
	logic [AW-1:0] q_base_q;
	logic [CW-1:0] q_n_q;
	logic [PW-1:0] q_old_q;
	logic [PW-1:0] q_new_q;
	logic          walk_act_q;
	logic [CW-1:0] walk_cnt_q;
	logic [PW-1:0] walk_ptr_q;
	logic [CW-1:0] cand_cnt_q;
	logic [PW-1:0] cand_ptr_q;
	logic          v_s1, v_s2, v_s3, t0_s1, t1_s1;
	logic [VW-1:0] mag_s2;
	logic [2*VW-1:0] sq_s3;
	logic signed [VW-1:0] min_q, max_q, mean_q, med1_q, med2_q;
	logic signed [SW-1:0] sum_q;
	logic [DW-1:0] var_q;
	logic [wss_pkg::SD_W-1:0] sd_q;
	logic [CW-1:0] lt_q, eq_q;
	logic [wss_pkg::TIME_W-1:0] first_q, last_q;
	logic          result_valid_q;

	logic          walk_start, div_start, sqrt_start;
	logic [DW-1:0] div_dividend;
	logic          div_done, sqrt_done;
	logic [DW-1:0] div_quo;
	logic [31:0]   sqrt_root;

	logic [VW-1:0] ra_data, rb_data;
	logic [wss_pkg::TIME_W-1:0] rt_data;
	logic [AW-1:0] rt_addr;

	logic signed [SW-1:0] sum_mag;
	logic signed [VW:0]   diff;
	logic [VW-1:0]        mean_lo;
	logic [CW-1:0]        k1, k2;
	logic [CW:0]          lt_ext, lteq_ext;
	logic                 hit1, hit2;
	logic signed [VW:0]   med_sum, med_adj;

	assign accept = start && !busy;
	assign ch_ok  = {1'b0, channel} < (wss_pkg::CHAN_W + 1)'(CHANNEL_COUNT);
	assign ch_idx = channel[CHW-1:0];
	assign busy   = state_q != wss_pkg::ST_IDLE;

	always_comb begin
		if (window_capacity == '0) begin
			cap_new = CW'(1);
		end else if (int'(window_capacity) > WINDOW_DEPTH) begin
			cap_new = CW'(WINDOW_DEPTH);
		end else begin
			cap_new = CW'(window_capacity);
		end
	end

	always_comb begin
		base_in   = AW'(ch_idx) * AW'(WINDOW_DEPTH);
		newest_in = (wp_q[ch_idx] == '0) ? PW'(cap_q - CW'(1)) : wp_q[ch_idx] - PW'(1);
		sum_mag   = sum_q[SW-1] ? -sum_q : sum_q;
		mean_lo   = div_quo[VW-1:0];
		diff      = $signed({rb_data[VW-1], rb_data}) - $signed({mean_q[VW-1], mean_q});
		k1        = (q_n_q - CW'(1)) >> 1;
		k2        = q_n_q >> 1;
		lt_ext    = {1'b0, lt_q};
		lteq_ext  = {1'b0, lt_q} + {1'b0, eq_q};
		hit1      = (lt_ext <= {1'b0, k1}) && ({1'b0, k1} < lteq_ext);
		hit2      = (lt_ext <= {1'b0, k2}) && ({1'b0, k2} < lteq_ext);
		med_sum   = $signed({med1_q[VW-1], med1_q}) + $signed({med2_q[VW-1], med2_q});
		med_adj   = med_sum + $signed((VW + 1)'(med_sum[VW]));
		rt_addr   = q_base_q + AW'((walk_cnt_q == '0) ? q_old_q : q_new_q);
	end

	// Query sequencer
	always_comb begin
		state_d      = state_q;
		walk_start   = 1'b0;
		div_start    = 1'b0;
		sqrt_start   = 1'b0;
		div_dividend = DW'(sum_mag);
		case (state_q)
			wss_pkg::ST_IDLE: begin
				if (accept && ch_ok && operation == wss_pkg::OP_QUERY
				    && held_q[ch_idx] != '0) begin
					state_d    = wss_pkg::ST_SUM;
					walk_start = 1'b1;
				end
			end
			wss_pkg::ST_SUM: begin
				if (!walk_act_q && !v_s1) begin
					state_d   = wss_pkg::ST_MEAN_DIV;
					div_start = 1'b1;
				end
			end
			wss_pkg::ST_MEAN_DIV: begin
				if (div_done) begin
					state_d    = wss_pkg::ST_VAR;
					walk_start = 1'b1;
				end
			end
			wss_pkg::ST_VAR: begin
				if (!walk_act_q && !v_s1 && !v_s2 && !v_s3) begin
					state_d      = wss_pkg::ST_VAR_DIV;
					div_start    = 1'b1;
					div_dividend = var_q;
				end
			end
			wss_pkg::ST_VAR_DIV: begin
				if (div_done) begin
					state_d    = wss_pkg::ST_SQRT;
					sqrt_start = 1'b1;
				end
			end
			wss_pkg::ST_SQRT: begin
				if (sqrt_done) begin
					state_d    = wss_pkg::ST_MED_SCAN;
					walk_start = 1'b1;
				end
			end
			wss_pkg::ST_MED_SCAN: begin
				if (!walk_act_q && !v_s1) begin
					state_d = wss_pkg::ST_MED_EVAL;
				end
			end
			wss_pkg::ST_MED_EVAL: begin
				if (cand_cnt_q == q_n_q - CW'(1)) begin
					state_d = wss_pkg::ST_DONE;
				end else begin
					state_d    = wss_pkg::ST_MED_SCAN;
					walk_start = 1'b1;
				end
			end
			wss_pkg::ST_DONE: begin
				state_d = wss_pkg::ST_IDLE;
			end
			default: begin
				state_d = wss_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= wss_pkg::ST_IDLE;
			cap_q          <= CW'(CAP_INIT);
			walk_act_q     <= 1'b0;
			v_s1           <= 1'b0;
			v_s2           <= 1'b0;
			v_s3           <= 1'b0;
			t0_s1          <= 1'b0;
			t1_s1          <= 1'b0;
			result_valid_q <= 1'b0;
			for (int i = 0; i < CHANNEL_COUNT; i++) begin
				wp_q[i]   <= '0;
				old_q[i]  <= '0;
				held_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (walk_start) begin
				walk_act_q <= 1'b1;
			end else if (walk_act_q && walk_cnt_q == q_n_q - CW'(1)) begin
				walk_act_q <= 1'b0;
			end
			v_s1  <= walk_act_q;
			t0_s1 <= walk_act_q && state_q == wss_pkg::ST_SUM && walk_cnt_q == CW'(0);
			t1_s1 <= walk_act_q && state_q == wss_pkg::ST_SUM && walk_cnt_q == CW'(1);
			v_s2  <= v_s1 && state_q == wss_pkg::ST_VAR;
			v_s3  <= v_s2;
			result_valid_q <= (state_q == wss_pkg::ST_DONE)
			                  || (accept && ch_ok && operation == wss_pkg::OP_QUERY
			                      && held_q[ch_idx] == '0);

			if (window_capacity_wr) begin
				cap_q <= cap_new;
				if (cap_new != cap_q) begin
					for (int i = 0; i < CHANNEL_COUNT; i++) begin
						wp_q[i]   <= '0;
						old_q[i]  <= '0;
						held_q[i] <= '0;
					end
				end
			end else if (accept && ch_ok && operation == wss_pkg::OP_ADD) begin
				if (held_q[ch_idx] < cap_q) begin
					held_q[ch_idx] <= held_q[ch_idx] + CW'(1);
				end else begin
					old_q[ch_idx] <= ring_inc(old_q[ch_idx], cap_q);
				end
				wp_q[ch_idx] <= ring_inc(wp_q[ch_idx], cap_q);
			end else if (accept && ch_ok && operation == wss_pkg::OP_CLEAR) begin
				wp_q[ch_idx]   <= '0;
				old_q[ch_idx]  <= '0;
				held_q[ch_idx] <= '0;
			end
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (accept && ch_ok && operation == wss_pkg::OP_QUERY) begin
			q_base_q <= base_in;
			q_n_q    <= held_q[ch_idx];
			q_old_q  <= old_q[ch_idx];
			q_new_q  <= newest_in;
			min_q    <= {1'b0, {(VW - 1){1'b1}}};
			max_q    <= {1'b1, {(VW - 1){1'b0}}};
			sum_q    <= '0;
		end

		if (walk_start) begin
			walk_cnt_q <= '0;
			walk_ptr_q <= (state_q == wss_pkg::ST_IDLE) ? old_q[ch_idx] : q_old_q;
		end else if (walk_act_q) begin
			walk_cnt_q <= walk_cnt_q + CW'(1);
			walk_ptr_q <= ring_inc(walk_ptr_q, cap_q);
		end

		if (t0_s1) begin
			first_q <= rt_data;
			last_q  <= rt_data;
		end else if (t1_s1) begin
			last_q <= rt_data;
		end

		if (v_s1 && state_q == wss_pkg::ST_SUM) begin
			if ($signed(rb_data) < min_q) begin
				min_q <= $signed(rb_data);
			end
			if ($signed(rb_data) > max_q) begin
				max_q <= $signed(rb_data);
			end
			sum_q <= sum_q + SW'($signed(rb_data));
		end

		if (state_q == wss_pkg::ST_MEAN_DIV && div_done) begin
			mean_q <= sum_q[SW-1] ? -$signed(mean_lo) : $signed(mean_lo);
			var_q  <= '0;
		end

		// Variance pipeline: difference, square, accumulate.
		if (v_s1 && state_q == wss_pkg::ST_VAR) begin
			mag_s2 <= diff[VW] ? VW'(-diff) : VW'(diff);
		end
		if (v_s2) begin
			sq_s3 <= mag_s2 * mag_s2;
		end
		if (v_s3) begin
			var_q <= var_q + DW'(sq_s3);
		end

		if (state_q == wss_pkg::ST_SQRT && sqrt_done) begin
			sd_q       <= sqrt_root[31] ? {wss_pkg::SD_W{1'b1}} : sqrt_root[30:0];
			cand_cnt_q <= '0;
			cand_ptr_q <= q_old_q;
			lt_q       <= '0;
			eq_q       <= '0;
		end

		// The candidate sits on read port A while port B walks the ring.
		if (v_s1 && state_q == wss_pkg::ST_MED_SCAN) begin
			if ($signed(rb_data) < $signed(ra_data)) begin
				lt_q <= lt_q + CW'(1);
			end
			if (rb_data == ra_data) begin
				eq_q <= eq_q + CW'(1);
			end
		end

		if (state_q == wss_pkg::ST_MED_EVAL) begin
			if (hit1) begin
				med1_q <= $signed(ra_data);
			end
			if (hit2) begin
				med2_q <= $signed(ra_data);
			end
			cand_cnt_q <= cand_cnt_q + CW'(1);
			cand_ptr_q <= ring_inc(cand_ptr_q, cap_q);
			lt_q       <= '0;
			eq_q       <= '0;
		end

		if (state_q == wss_pkg::ST_DONE) begin
			lowest_value  <= min_q;
			highest_value <= max_q;
			mean_value    <= mean_q;
			middle_value  <= med_adj[VW:1];
			spread_value  <= sd_q;
			held_samples  <= wss_pkg::COUNT_W'(q_n_q);
			first_time    <= first_q;
			last_time     <= last_q;
		end else if (accept && ch_ok && operation == wss_pkg::OP_QUERY
		             && held_q[ch_idx] == '0) begin
			lowest_value  <= '0;
			highest_value <= '0;
			mean_value    <= '0;
			middle_value  <= '0;
			spread_value  <= '0;
			held_samples  <= '0;
			first_time    <= '0;
			last_time     <= '0;
		end
	end

	assign result_valid = result_valid_q;

	wss_store #(
		.ENTRIES (ENTRIES),
		.AW      (AW)
	) u_store (
		.clk     (clk),
		.we      (accept && ch_ok && operation == wss_pkg::OP_ADD && !window_capacity_wr),
		.waddr   (base_in + AW'(wp_q[ch_idx])),
		.wsample (sample_value),
		.wtime   (sample_time),
		.ra_addr (q_base_q + AW'(cand_ptr_q)),
		.ra_data (ra_data),
		.rb_addr (q_base_q + AW'(walk_ptr_q)),
		.rb_data (rb_data),
		.rt_addr (rt_addr),
		.rt_data (rt_data)
	);

	wss_div #(
		.DW (DW),
		.VW (CW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (q_n_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	wss_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sqrt_start),
		.radicand (div_quo[63:0]),
		.done     (sqrt_done),
		.root     (sqrt_root)
	);

	// A reported window never holds more samples than the ring capacity.
	a_count_in_cap: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> CW'(held_samples) <= cap_q)
		else $error("reported count exceeds the window capacity");

	// The median and the mean lie between the minimum and the maximum.
	a_median_order: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (lowest_value <= middle_value) && (middle_value <= highest_value))
		else $error("median outside min/max");

	a_mean_order: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (lowest_value <= mean_value) && (mean_value <= highest_value))
		else $error("mean outside min/max");

	// An empty window reports zero in every statistic.
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && held_samples == '0 |-> lowest_value == '0 && highest_value == '0
		&& spread_value == '0 && first_time == '0)
		else $error("empty window result is not zero");

	// The shared divider is never restarted while its result is still pending.
	a_div_handoff: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |=> !div_start)
		else $error("divider restarted back to back");

endmodule

@@ bench/tb_windowed_sample_statistics.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Windowed sample statistics testbench
// A table of directed items, then random add, query, clear and unused-code
// traffic on several window capacities. Each query result is checked field
// by field against its table value or a predictor kept in this bench.
// ---------------------------------------------------------------------------
module tb_windowed_sample_statistics;

	localparam int DEPTH = wss_pkg::WINDOW_DEPTH_DEF;
	localparam int CHANS = wss_pkg::CHANNEL_COUNT_DEF;

	// Operation code with no function; the block ignores it.
	localparam logic [wss_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

	typedef struct {
		logic signed [wss_pkg::VALUE_W-1:0] min_v;
		logic signed [wss_pkg::VALUE_W-1:0] max_v;
		logic signed [wss_pkg::VALUE_W-1:0] mean_v;
		logic signed [wss_pkg::VALUE_W-1:0] median_v;
		logic [wss_pkg::SD_W-1:0]           sd;
		logic [wss_pkg::COUNT_W-1:0]        count;
		logic [wss_pkg::TIME_W-1:0]         first_t;
		logic [wss_pkg::TIME_W-1:0]         last_t;
	} stats_t;

	typedef struct {
		logic [wss_pkg::OP_W-1:0]           op;
		logic [wss_pkg::CHAN_W-1:0]         ch;
		logic signed [wss_pkg::VALUE_W-1:0] val;
		logic [wss_pkg::TIME_W-1:0]         tm;
		bit                                 typed;
		stats_t                             want;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [wss_pkg::OP_W-1:0] operation = '0;
	logic [wss_pkg::CHAN_W-1:0] channel = '0;
	logic signed [wss_pkg::VALUE_W-1:0] sample_value = '0;
	logic [wss_pkg::TIME_W-1:0] sample_time = '0;
	logic window_capacity_wr = 1'b0;
	logic [wss_pkg::COUNT_W-1:0] window_capacity = '0;
	logic result_valid;
	logic signed [wss_pkg::VALUE_W-1:0] lowest_value, highest_value, mean_value, middle_value;
	logic [wss_pkg::SD_W-1:0] spread_value;
	logic [wss_pkg::COUNT_W-1:0] held_samples;
	logic [wss_pkg::TIME_W-1:0] first_time, last_time;

	windowed_sample_statistics u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.operation(operation), .channel(channel),
		.sample_value(sample_value), .sample_time(sample_time),
		.window_capacity_wr(window_capacity_wr), .window_capacity(window_capacity),
		.result_valid(result_valid), .lowest_value(lowest_value),
		.highest_value(highest_value), .mean_value(mean_value),
		.middle_value(middle_value), .spread_value(spread_value),
		.held_samples(held_samples), .first_time(first_time), .last_time(last_time)
	);

	always #10 clk = ~clk;

	// Shadow copy of the channel rings.
	int          ring_val [CHANS][DEPTH];
	logic [63:0] ring_time[CHANS][DEPTH];
	int          wr_pos[CHANS];
	int          old_pos[CHANS];
	int          held[CHANS];
	int          cap_now = wss_pkg::CAP_RESET;
	int          win_buf[DEPTH];

	stats_t expected_stats[$];
	int     errors = 0;
	bit     idle_on = 1'b1;

	function automatic logic [63:0] floor_sqrt(logic [63:0] x);
		logic [63:0] res, bitv;
		res = '0;
		bitv = 64'd1 << 62;
		while (bitv > x) bitv = bitv >> 2;
		while (bitv != 0) begin
			if (x >= res + bitv) begin
				x = x - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res;
	endfunction

	function automatic stats_t window_stats(int ch);
		stats_t s;
		int n, idx, key, j;
		longint sum, mean_l, med_l, diff;
		logic [63:0] mag, sq, var_v, root;
		logic [127:0] acc;
		s = '{default: '0};
		n = held[ch];
		if (n == 0) return s;
		idx = old_pos[ch];
		for (int i = 0; i < n; i++) begin
			win_buf[i] = ring_val[ch][idx];
			idx = (idx + 1) % cap_now;
		end
		s.min_v = win_buf[0];
		s.max_v = win_buf[0];
		sum = 0;
		for (int i = 0; i < n; i++) begin
			if (win_buf[i] < s.min_v) s.min_v = win_buf[i];
			if (win_buf[i] > s.max_v) s.max_v = win_buf[i];
			sum += win_buf[i];
		end
		mean_l = sum / longint'(n);
		acc = 0;
		for (int i = 0; i < n; i++) begin
			diff = longint'(win_buf[i]) - mean_l;
			mag = (diff < 0) ? 64'(-diff) : 64'(diff);
			sq = mag * mag;
			acc = acc + {64'd0, sq};
		end
		var_v = 64'(acc / 128'(n));
		root = floor_sqrt(var_v);
		s.sd = (root > 64'h7FFF_FFFF) ? 31'h7FFF_FFFF : root[30:0];
		for (int i = 1; i < n; i++) begin
			key = win_buf[i];
			j = i - 1;
			while (j >= 0 && win_buf[j] > key) begin
				win_buf[j + 1] = win_buf[j];
				j--;
			end
			win_buf[j + 1] = key;
		end
		if (n % 2 == 0)
			med_l = (longint'(win_buf[n/2 - 1]) + longint'(win_buf[n/2])) / 2;
		else
			med_l = win_buf[n/2];
		s.mean_v = mean_l[31:0];
		s.median_v = med_l[31:0];
		s.count = wss_pkg::COUNT_W'(n);
		s.first_t = ring_time[ch][old_pos[ch]];
		s.last_t = ring_time[ch][(wr_pos[ch] + cap_now - 1) % cap_now];
		return s;
	endfunction

	task automatic clear_all();
		for (int c = 0; c < CHANS; c++) begin
			wr_pos[c] = 0;
			old_pos[c] = 0;
			held[c] = 0;
		end
	endtask

	task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
		$display("MISMATCH %s: got %h expected %h at %0t", field, got, want, $realtime);
		errors++;
	endtask

	// Results are sampled at the edge that ends their one valid cycle.
	always @(posedge clk) begin
		stats_t w;
		if (arst_n && result_valid) begin
			if (expected_stats.size() == 0) begin
				report_mismatch("unexpected result", 64'(held_samples), 64'd0);
			end else begin
				w = expected_stats.pop_front();
				if (lowest_value !== w.min_v)
					report_mismatch("lowest_value", 64'(lowest_value), 64'(w.min_v));
				if (highest_value !== w.max_v)
					report_mismatch("highest_value", 64'(highest_value), 64'(w.max_v));
				if (mean_value !== w.mean_v)
					report_mismatch("mean_value", 64'(mean_value), 64'(w.mean_v));
				if (middle_value !== w.median_v)
					report_mismatch("middle_value", 64'(middle_value), 64'(w.median_v));
				if (spread_value !== w.sd)
					report_mismatch("spread_value", 64'(spread_value), 64'(w.sd));
				if (held_samples !== w.count)
					report_mismatch("held_samples", 64'(held_samples), 64'(w.count));
				if (first_time !== w.first_t) report_mismatch("first_time", first_time, w.first_t);
				if (last_time !== w.last_t) report_mismatch("last_time", last_time, w.last_t);
			end
		end
	end

	// Drives one item, waits for it to be taken and updates the shadow rings.
	task automatic send_item(logic [wss_pkg::OP_W-1:0] op, logic [wss_pkg::CHAN_W-1:0] ch,
		logic signed [wss_pkg::VALUE_W-1:0] val, logic [wss_pkg::TIME_W-1:0] tm,
		bit typed, stats_t want);
		int c;
		operation <= op;
		channel <= ch;
		sample_value <= val;
		sample_time <= tm;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		c = int'(ch);
		if (c < CHANS) begin
			if (op == wss_pkg::OP_ADD) begin
				if (held[c] < cap_now) held[c]++;
				else old_pos[c] = (old_pos[c] + 1) % cap_now;
				ring_val[c][wr_pos[c]] = val;
				ring_time[c][wr_pos[c]] = tm;
				wr_pos[c] = (wr_pos[c] + 1) % cap_now;
			end else if (op == wss_pkg::OP_QUERY) begin
				expected_stats.push_back(typed ? want : window_stats(c));
			end else if (op == wss_pkg::OP_CLEAR) begin
				held[c] = 0;
				wr_pos[c] = 0;
				old_pos[c] = 0;
			end
		end
		if (idle_on && $urandom_range(0, 99) < 9) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
	endtask

	// Capacity is only written once the block has drained completely.
	task automatic set_capacity(int value);
		int eff;
		if (start) start <= 1'b0;
		@(posedge clk);
		while (expected_stats.size() != 0 || busy) @(posedge clk);
		repeat (10) @(posedge clk);
		window_capacity <= wss_pkg::COUNT_W'(value);
		window_capacity_wr <= 1'b1;
		@(posedge clk);
		window_capacity_wr <= 1'b0;
		eff = (value == 0) ? 1 : (value > DEPTH ? DEPTH : value);
		if (eff != cap_now) begin
			cap_now = eff;
			clear_all();
		end
	endtask

	initial begin
		#50_000_000;
		$display("Verification failed");
		$finish;
	end

	initial begin
		dir_row_t rows[$];
		stats_t none, one;
		int caps[$];
		int r, sel;
		logic [wss_pkg::OP_W-1:0] op;
		logic [wss_pkg::CHAN_W-1:0] ch;
		logic signed [wss_pkg::VALUE_W-1:0] val;

		none = '{default: '0};
		one = '{32'sh0005_0000, 32'sh0005_0000, 32'sh0005_0000, 32'sh0005_0000,
			31'd0, 11'd1, 64'd1, 64'd1};
		clear_all();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		rows.push_back('{wss_pkg::OP_QUERY, 4'd0, 32'sd0, 64'd0, 1'b1, none});
		rows.push_back('{wss_pkg::OP_ADD, 4'd0, 32'sh7FFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
			1'b0, none});
		rows.push_back('{wss_pkg::OP_ADD, 4'd0, 32'sh8000_0000, 64'd0, 1'b0, none});
		rows.push_back('{wss_pkg::OP_QUERY, 4'd0, 32'sd0, 64'd0, 1'b0, none});
		rows.push_back('{wss_pkg::OP_ADD, 4'd10, 32'sh0005_0000, 64'd1, 1'b0, none});
		rows.push_back('{wss_pkg::OP_QUERY, 4'd10, 32'sd0, 64'd0, 1'b1, one});
		rows.push_back('{wss_pkg::OP_ADD, 4'd11, 32'sd7, 64'd9, 1'b0, none});
		rows.push_back('{wss_pkg::OP_QUERY, 4'd11, 32'sd0, 64'd0, 1'b0, none});
		rows.push_back('{wss_pkg::OP_QUERY, 4'd15, 32'sd0, 64'd0, 1'b0, none});
		rows.push_back('{OP_UNUSED, 4'd0, 32'sd0, 64'd0, 1'b0, none});
		rows.push_back('{wss_pkg::OP_CLEAR, 4'd15, 32'sd0, 64'd0, 1'b0, none});
		rows.push_back('{wss_pkg::OP_QUERY, 4'd0, 32'sd0, 64'd0, 1'b0, none});
		rows.push_back('{wss_pkg::OP_CLEAR, 4'd0, 32'sd0, 64'd0, 1'b0, none});
		rows.push_back('{wss_pkg::OP_QUERY, 4'd0, 32'sd0, 64'd0, 1'b1, none});
		rows.push_back('{wss_pkg::OP_ADD, 4'd3, -32'sd3, 64'h8000_0000_0000_0000, 1'b0, none});
		rows.push_back('{wss_pkg::OP_ADD, 4'd3, 32'sd10, 64'h5555_AAAA_5555_AAAA, 1'b0, none});
		rows.push_back('{wss_pkg::OP_ADD, 4'd3, -32'sd3, 64'hAAAA_5555_AAAA_5555, 1'b0, none});
		rows.push_back('{wss_pkg::OP_QUERY, 4'd3, 32'sd0, 64'd0, 1'b0, none});
		rows.push_back('{wss_pkg::OP_ADD, 4'd3, 32'sd4, 64'd77, 1'b0, none});
		rows.push_back('{wss_pkg::OP_QUERY, 4'd3, 32'sd0, 64'd0, 1'b0, none});
		foreach (rows[i])
			send_item(rows[i].op, rows[i].ch, rows[i].val, rows[i].tm, rows[i].typed,
				rows[i].want);

		// Out-of-range writes clamp; repeated values must keep the rings.
		caps = '{4, 1, 16, 0, 2, 7, 7, 3, 2047, 1024};
		foreach (caps[p]) begin
			set_capacity(caps[p]);
			idle_on = (p != 2);
			for (int k = 0; k < 110; k++) begin
				r = $urandom_range(0, 99);
				ch = wss_pkg::CHAN_W'($urandom_range(0, CHANS - 1));
				if (r < 62) op = wss_pkg::OP_ADD;
				else if (r < 84) op = wss_pkg::OP_QUERY;
				else if (r < 92) op = wss_pkg::OP_CLEAR;
				else if (r < 95) op = OP_UNUSED;
				else begin
					op = wss_pkg::OP_W'($urandom_range(0, 3));
					ch = wss_pkg::CHAN_W'($urandom_range(CHANS, 15));
				end
				sel = $urandom_range(0, 9);
				if (sel == 0) val = 32'sh7FFF_FFFF;
				else if (sel == 1) val = 32'sh8000_0000;
				else if (sel < 5) val = $signed($urandom_range(0, 8)) - 4;
				else val = $urandom;
				send_item(op, ch, val, {$urandom, $urandom}, 1'b0, none);
			end
		end

		if (start) start <= 1'b0;
		@(posedge clk);
		while (expected_stats.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (errors == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
